// File: design/tkd_pkg.sv
// Shared types, key codes and decode tables for the terminal key decoder.
package tkd_pkg;

    localparam logic [8:0] KEY_ESC   = 9'd27;
    localparam logic [8:0] KEY_LEFT  = 9'd256;
    localparam logic [8:0] KEY_RIGHT = 9'd257;
    localparam logic [8:0] KEY_UP    = 9'd258;
    localparam logic [8:0] KEY_DOWN  = 9'd259;
    localparam logic [8:0] KEY_DEL   = 9'd260;
    localparam logic [8:0] KEY_HOME  = 9'd261;
    localparam logic [8:0] KEY_END   = 9'd262;
    localparam logic [8:0] KEY_PGUP  = 9'd263;
    localparam logic [8:0] KEY_PGDN  = 9'd264;
    localparam logic [8:0] KEY_CTRL_Q = 9'h011;

    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_BRACKET = 8'h5b;
    localparam logic [7:0] CH_OH      = 8'h4f;
    localparam logic [7:0] CH_TILDE   = 8'h7e;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_1       = 8'h31;
    localparam logic [7:0] CH_3       = 8'h33;
    localparam logic [7:0] CH_4       = 8'h34;
    localparam logic [7:0] CH_5       = 8'h35;
    localparam logic [7:0] CH_6       = 8'h36;
    localparam logic [7:0] CH_7       = 8'h37;
    localparam logic [7:0] CH_8       = 8'h38;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [7:0] ROWS_RESET = 8'd24;
    localparam logic [7:0] COLS_RESET = 8'd80;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_ESC     = 6'b000010,
        PH_BRACKET = 6'b000100,
        PH_OH      = 6'b001000,
        PH_JUNK    = 6'b010000,
        PH_DIGIT   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] in_byte;
    } in_req_t;

    typedef struct packed {
        logic [8:0] key_code;
        logic       quit_request;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } out_req_t;

    typedef struct packed {
        logic       valid;
        logic [8:0] code;
    } key_event_t;

    function automatic logic [8:0] letter_key(input logic [7:0] b);
        logic [8:0] k;
        case (b)
            CH_A:    k = KEY_UP;
            CH_B:    k = KEY_DOWN;
            CH_C:    k = KEY_RIGHT;
            CH_D:    k = KEY_LEFT;
            CH_H:    k = KEY_HOME;
            CH_F:    k = KEY_END;
            default: k = KEY_ESC;
        endcase
        return k;
    endfunction

    function automatic logic [8:0] digit_key(input logic [7:0] d);
        logic [8:0] k;
        case (d) inside
            CH_1, CH_7: k = KEY_HOME;
            CH_3:       k = KEY_DEL;
            CH_4, CH_8: k = KEY_END;
            CH_5:       k = KEY_PGUP;
            CH_6:       k = KEY_PGDN;
            default:    k = KEY_ESC;
        endcase
        return k;
    endfunction

endpackage

// File: design/tkd_parser.sv
// Escape sequence parser: phase state machine and held digit.
module tkd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  tkd_pkg::in_req_t req,
    output tkd_pkg::key_event_t ev
);
    import tkd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] digit_reg, digit_next;

    always_comb
    begin
        phase_next = PH_IDLE;
        digit_next = digit_reg;
        ev.valid   = 1'b0;
        ev.code    = KEY_ESC;
        case (phase_reg)
            PH_IDLE:
            begin
                if (!req.command)
                begin
                    if (req.in_byte == CH_ESC)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        ev.valid = 1'b1;
                        ev.code  = {1'b0, req.in_byte};
                    end
                end
            end
            PH_ESC:
            begin
                if (req.command)
                begin
                    ev.valid = 1'b1;
                end
                else if (req.in_byte == CH_BRACKET)
                begin
                    phase_next = PH_BRACKET;
                end
                else if (req.in_byte == CH_OH)
                begin
                    phase_next = PH_OH;
                end
                else
                begin
                    phase_next = PH_JUNK;
                end
            end
            PH_BRACKET:
            begin
                if (req.command)
                begin
                    ev.valid = 1'b1;
                end
                else if (req.in_byte inside {[CH_ZERO:CH_NINE]})
                begin
                    digit_next = req.in_byte;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    ev.valid = 1'b1;
                    ev.code  = letter_key(req.in_byte);
                end
            end
            PH_OH:
            begin
                ev.valid = 1'b1;
                if (!req.command && (req.in_byte == CH_H || req.in_byte == CH_F))
                begin
                    ev.code = letter_key(req.in_byte);
                end
            end
            PH_DIGIT:
            begin
                ev.valid = 1'b1;
                if (!req.command && req.in_byte == CH_TILDE)
                begin
                    ev.code = digit_key(digit_reg);
                end
            end
            PH_JUNK:
            begin
                ev.valid = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            digit_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
        end
    end

endmodule

// File: design/tkd_cursor.sv
// Clamped cursor update and result formatting for each decoded key.
module tkd_cursor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  tkd_pkg::key_event_t ev,
    input  logic [7:0]          rows,
    input  logic [7:0]          cols,
    output tkd_pkg::out_req_t   result
);
    import tkd_pkg::*;

    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] last_col;
    logic [7:0] last_row;

    assign last_col = (cols == 8'd0) ? 8'd0 : cols - 8'd1;
    assign last_row = (rows == 8'd0) ? 8'd0 : rows - 8'd1;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        case (ev.code)
            KEY_LEFT:  if (x_reg != 8'd0) x_next = x_reg - 8'd1;
            KEY_RIGHT: if (x_reg < last_col) x_next = x_reg + 8'd1;
            KEY_UP:    if (y_reg != 8'd0) y_next = y_reg - 8'd1;
            KEY_DOWN:  if (y_reg < last_row) y_next = y_reg + 8'd1;
            KEY_HOME:  x_next = 8'd0;
            KEY_END:   x_next = last_col;
            KEY_PGUP:  y_next = 8'd0;
            KEY_PGDN:  y_next = last_row;
            default:   x_next = x_reg;
        endcase
    end

    assign result.key_code     = ev.code;
    assign result.quit_request = (ev.code == KEY_CTRL_Q);
    assign result.cursor_col   = x_next;
    assign result.cursor_row   = y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= 8'd0;
            y_reg <= 8'd0;
        end
        else if (step && ev.valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

endmodule

// File: design/terminal_key_decode_cursor.sv
// Top level of the terminal key decoder with its input stage and result register.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------
//  byte    | byte_valid/byte_ready  | byte_data: command, in_byte
//  key     | key_valid/key_ready    | key_data: key_code, quit_request,
//          |                        |           cursor_col, cursor_row
//  cfg     | cfg_valid/cfg_ready    | cfg_index (0 rows, 1 cols), cfg_data
//
// One byte or timeout request is taken every cycle while the result is not stalled;
// the last byte of a key passes the input register and then the result register.
// Reset returns the parser to idle, the cursor to the origin and the screen
// size to 24 by 80. A stalled result holds the input stage, and the stage
// still takes a new request in the cycle that the result is taken.
module terminal_key_decode_cursor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  tkd_pkg::in_req_t  byte_data,
    output logic              key_valid,
    input  logic              key_ready,
    output tkd_pkg::out_req_t key_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);
    import tkd_pkg::*;

    logic       stage_valid_reg, stage_valid_next;
    in_req_t    stage_data_reg;
    logic       out_valid_reg, out_valid_next;
    out_req_t   out_data_reg;
    logic [7:0] rows_reg;
    logic [7:0] cols_reg;
    logic       advance;
    key_event_t ev;
    out_req_t   result;

    assign advance    = stage_valid_reg && (!out_valid_reg || key_ready);
    assign byte_ready = !stage_valid_reg || advance;
    assign cfg_ready  = 1'b1;
    assign key_valid  = out_valid_reg;
    assign key_data   = out_data_reg;

    assign stage_valid_next = (byte_valid && byte_ready) ? 1'b1 :
                              (advance ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = advance ? ev.valid : (out_valid_reg && !key_ready);

    tkd_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (stage_data_reg),
        .ev    (ev)
    );

    tkd_cursor u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ev     (ev),
        .rows   (rows_reg),
        .cols   (cols_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            rows_reg        <= ROWS_RESET;
            cols_reg        <= COLS_RESET;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ROWS: rows_reg <= cfg_data;
                    CFG_COLS: cols_reg <= cfg_data;
                    default:  rows_reg <= rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            stage_data_reg <= byte_data;
        end
        if (advance && ev.valid)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// File: design/tkd_checker.sv
// Port-level checks for the terminal key decoder and their binding.
module tkd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              byte_valid,
    input logic              byte_ready,
    input tkd_pkg::in_req_t  byte_data,
    input logic              key_valid,
    input logic              key_ready,
    input tkd_pkg::out_req_t key_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic              cfg_index,
    input logic [7:0]        cfg_data
);
    import tkd_pkg::*;

    a_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_ready |=> key_valid && $stable(key_data))
        else $error("Stalled key result changed or was withdrawn.");

    a_quit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid |-> key_data.quit_request == (key_data.key_code == KEY_CTRL_Q))
        else $error("Quit flag does not match the key code.");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid |-> key_data.key_code <= KEY_PGDN)
        else $error("Key code out of range.");

    a_home_pgup: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && (key_data.key_code == KEY_HOME || key_data.key_code == KEY_PGUP)
        |-> (key_data.key_code == KEY_HOME) ? (key_data.cursor_col == 8'd0)
                                             : (key_data.cursor_row == 8'd0))
        else $error("Home or page up did not reach the edge.");

endmodule

bind terminal_key_decode_cursor tkd_checker u_tkd_checker (.*);

// File: test/terminal_key_decode_cursor_tb.sv
// Self-checking testbench for the terminal key decoder: predicts every key and cursor position.
module terminal_key_decode_cursor_tb;
    import tkd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int RUN_ITEMS   = 235;

    class key_tracker;
        phase_t     phase;
        logic [7:0] digit;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] rows;
        logic [7:0] cols;
        out_req_t   pending_keys[$];
        int         mismatches;

        function new();
            phase      = PH_IDLE;
            digit      = 8'd0;
            col        = 8'd0;
            row        = 8'd0;
            rows       = ROWS_RESET;
            cols       = COLS_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] val);
            if (idx == CFG_ROWS)
                rows = val;
            else
                cols = val;
        endfunction

        function logic [8:0] letter_to_key(logic [7:0] b);
            case (b)
                CH_A:    return KEY_UP;
                CH_B:    return KEY_DOWN;
                CH_C:    return KEY_RIGHT;
                CH_D:    return KEY_LEFT;
                CH_H:    return KEY_HOME;
                CH_F:    return KEY_END;
                default: return KEY_ESC;
            endcase
        endfunction

        function logic [8:0] digit_to_key(logic [7:0] d);
            case (d)
                CH_1, CH_7: return KEY_HOME;
                CH_3:       return KEY_DEL;
                CH_4, CH_8: return KEY_END;
                CH_5:       return KEY_PGUP;
                CH_6:       return KEY_PGDN;
                default:    return KEY_ESC;
            endcase
        endfunction

        function void move_and_note(logic [8:0] key);
            logic [7:0] last_col;
            logic [7:0] last_row;
            out_req_t   k;
            last_col = (cols == 8'd0) ? 8'd0 : cols - 8'd1;
            last_row = (rows == 8'd0) ? 8'd0 : rows - 8'd1;
            case (key)
                KEY_LEFT:  if (col != 8'd0) col = col - 8'd1;
                KEY_RIGHT: if (col < last_col) col = col + 8'd1;
                KEY_UP:    if (row != 8'd0) row = row - 8'd1;
                KEY_DOWN:  if (row < last_row) row = row + 8'd1;
                KEY_HOME:  col = 8'd0;
                KEY_END:   col = last_col;
                KEY_PGUP:  row = 8'd0;
                KEY_PGDN:  row = last_row;
                default:   ;
            endcase
            k.key_code     = key;
            k.quit_request = (key == KEY_CTRL_Q);
            k.cursor_col   = col;
            k.cursor_row   = row;
            pending_keys.push_back(k);
        endfunction

        function void take_request(in_req_t r);
            logic [7:0] b;
            b = r.in_byte;
            if (phase == PH_IDLE) begin
                if (!r.command) begin
                    if (b == CH_ESC)
                        phase = PH_ESC;
                    else
                        move_and_note({1'b0, b});
                end
            end else if (r.command || phase == PH_JUNK) begin
                phase = PH_IDLE;
                move_and_note(KEY_ESC);
            end else if (phase == PH_ESC) begin
                if (b == CH_BRACKET)
                    phase = PH_BRACKET;
                else if (b == CH_OH)
                    phase = PH_OH;
                else
                    phase = PH_JUNK;
            end else if (phase == PH_BRACKET) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    digit = b;
                    phase = PH_DIGIT;
                end else begin
                    phase = PH_IDLE;
                    move_and_note(letter_to_key(b));
                end
            end else if (phase == PH_OH) begin
                phase = PH_IDLE;
                move_and_note((b == CH_H || b == CH_F) ? letter_to_key(b) : KEY_ESC);
            end else begin
                phase = PH_IDLE;
                move_and_note((b == CH_TILDE) ? digit_to_key(digit) : KEY_ESC);
            end
        endfunction

        task report(string what, logic [8:0] got, logic [8:0] want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_key(out_req_t got);
            out_req_t want;
            if (pending_keys.size() == 0) begin
                report("unexpected key", got.key_code, 9'd0);
            end else begin
                want = pending_keys.pop_front();
                if (got.key_code !== want.key_code)
                    report("key_code", got.key_code, want.key_code);
                if (got.quit_request !== want.quit_request)
                    report("quit_request", 9'(got.quit_request), 9'(want.quit_request));
                if (got.cursor_col !== want.cursor_col)
                    report("cursor_col", 9'(got.cursor_col), 9'(want.cursor_col));
                if (got.cursor_row !== want.cursor_row)
                    report("cursor_row", 9'(got.cursor_row), 9'(want.cursor_row));
            end
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_ready;
    in_req_t    byte_data;
    logic       key_valid;
    logic       key_ready;
    out_req_t   key_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    key_tracker sb;
    bit         calm;
    bit         hold_go;
    logic       hold;
    int         cycle_count;
    int         bytes_sent;

    logic [7:0] csi_letters [6] = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};

    terminal_key_decode_cursor u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .key_valid  (key_valid),
        .key_ready  (key_ready),
        .key_data   (key_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (key_valid && key_ready)
            sb.check_key(key_data);
        if (hold)
            key_ready <= 1'b0;
        else if (calm)
            key_ready <= 1'b1;
        else
            key_ready <= ($urandom_range(99) >= 24);
    end

    // The receiver holds off for a long stretch so that the block fills up.
    initial
    begin
        hold <= 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    task automatic send_req(input logic cmd, input logic [7:0] b);
        in_req_t r;
        r.command = cmd;
        r.in_byte = b;
        if (!calm) begin
            while ($urandom_range(99) < 24) begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
        end
        byte_valid <= 1'b1;
        byte_data  <= r;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        sb.take_request(r);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(1'b0, b);
    endtask

    task automatic send_timeout();
        send_req(1'b1, 8'($urandom_range(255)));
    endtask

    task automatic send_random_run();
        int pick;
        pick = $urandom_range(99);
        if (pick < 22) begin
            send_byte(8'($urandom_range(255)));
        end else if (pick < 38) begin
            send_byte(CH_ESC);
            send_byte(CH_BRACKET);
            send_byte(csi_letters[$urandom_range(5)]);
        end else if (pick < 52) begin
            send_byte(CH_ESC);
            send_byte(CH_BRACKET);
            send_byte(CH_ZERO + 8'($urandom_range(9)));
            send_byte(CH_TILDE);
        end else if (pick < 60) begin
            send_byte(CH_ESC);
            send_byte(CH_OH);
            send_byte($urandom_range(1) ? CH_H : CH_F);
        end else if (pick < 65) begin
            send_byte(8'($urandom_range(31)));
        end else if (pick < 71) begin
            send_timeout();
        end else if (pick < 79) begin
            send_byte(CH_ESC);
            case ($urandom_range(3))
                0: ;
                1: send_byte(CH_BRACKET);
                2: send_byte(CH_OH);
                default:
                begin
                    send_byte(CH_BRACKET);
                    send_byte(CH_ZERO + 8'($urandom_range(9)));
                end
            endcase
            send_timeout();
        end else if (pick < 87) begin
            send_byte(CH_ESC);
            send_byte(8'($urandom_range(255)));
            if ($urandom_range(1))
                send_byte(8'($urandom_range(255)));
            else
                send_timeout();
        end else if (pick < 93) begin
            send_byte(CH_ESC);
            send_byte(CH_BRACKET);
            send_byte(8'($urandom_range(255)));
        end else begin
            send_byte(CH_ESC);
            if ($urandom_range(1)) begin
                send_byte(CH_BRACKET);
                send_byte(CH_ZERO + 8'($urandom_range(9)));
            end else begin
                send_byte(CH_OH);
            end
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_for_keys();
        byte_valid <= 1'b0;
        while (sb.pending_keys.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] rows_set [7];
        logic [7:0] cols_set [7];
        int         target;
        sb          = new();
        calm        = 1'b0;
        hold_go     = 1'b0;
        cycle_count = 0;
        bytes_sent  = 0;
        rows_set    = '{ROWS_RESET, 8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(255)),
                        8'($urandom_range(255))};
        cols_set    = '{COLS_RESET, 8'd1, 8'd255, 8'd0, 8'd5, 8'($urandom_range(255)),
                        8'($urandom_range(255))};
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_data  <= '0;
        key_ready  <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_ROWS;
        cfg_data   <= 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(KEY_CTRL_Q[7:0]);
        send_timeout();
        send_byte(CH_ESC);
        send_byte(CH_BRACKET);
        send_byte(CH_A);
        send_byte(CH_ESC);
        send_byte(CH_OH);
        send_byte(CH_F);
        send_byte(CH_ESC);
        send_byte(CH_BRACKET);
        send_byte(CH_6);
        send_byte(CH_TILDE);
        send_byte(CH_ESC);
        send_timeout();
        send_byte(CH_ESC);
        send_byte(8'h78);
        send_byte(8'h79);
        send_byte(CH_ESC);
        send_byte(CH_BRACKET);
        send_byte(CH_NINE);
        send_byte(CH_TILDE);
        send_byte(CH_ESC);
        send_byte(CH_BRACKET);
        send_byte(CH_5);
        send_byte(8'h71);

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                wait_for_keys();
                write_reg(CFG_ROWS, rows_set[p]);
                write_reg(CFG_COLS, cols_set[p]);
            end
            calm = (p == 3);
            if (p == 2)
                hold_go = 1'b1;
            target = bytes_sent + RUN_ITEMS;
            while (bytes_sent < target)
                send_random_run();
        end

        wait_for_keys();
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
